/* hdl/cell_allocator_with_hold_time_defines.svh */
// assertion macros shared by the checker
`ifndef CELL_ALLOCATOR_WITH_HOLD_TIME_DEFINES_SVH
`define CELL_ALLOCATOR_WITH_HOLD_TIME_DEFINES_SVH

// consequent checked in the same cycle
`define CAH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define CAH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cah_pkg.sv */
`timescale 1ns / 1ps

package cah_pkg;

  localparam int REQ_W      = 2;
  localparam int ID_W       = 10;
  localparam int FRAME_W    = 32;
  localparam int CIU_W      = 7;
  localparam int HOLD_W     = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_CELL_W = 6;

  localparam int DEF_MAX_CELLS   = 64;
  localparam int DEF_MAX_RECORDS = 1024;

  localparam logic [CIU_W-1:0]  CIU_RESET  = 7'd16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd120;

  typedef enum logic [REQ_W-1:0] {
    REQ_TOUCH = 2'd0,
    REQ_PLACE = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_PROBE = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_IN_USE = 1'b0,
    REG_HOLD_FRAMES  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_last;
    logic pipe_empty;
    logic out_free;
  } status_t;

  // zero counts as one, large values saturate at the cell count
  function automatic logic [8:0] eff_budget(input logic [CIU_W-1:0] v, input int max_cells);
    logic [8:0] w;
    logic [8:0] m;
    w = 9'(v);
    m = 9'(max_cells);
    if (w == 9'd0) begin
      eff_budget = 9'd1;
    end else if (w > m) begin
      eff_budget = m;
    end else begin
      eff_budget = w;
    end
  endfunction

endpackage

/* hdl/cah_ram.sv */
`timescale 1ns / 1ps

module cah_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/cah_ctrl.sv */
`timescale 1ns / 1ps

module cah_ctrl import cah_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready       = (state_r == ST_IDLE);
  assign cmd.accept     = in_valid && (state_r == ST_IDLE);
  assign cmd.clear_step = (state_r == ST_CLEAR);
  assign cmd.scan_step  = (state_r == ST_SCAN);
  assign cmd.commit     = (state_r == ST_COMMIT) && st.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (st.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (st.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (st.pipe_empty) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/cah_dp.sv */
`timescale 1ns / 1ps

module cah_dp import cah_pkg::*; #(
  parameter int MAX_CELLS   = DEF_MAX_CELLS,
  parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               st,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [ID_W-1:0]       in_record_id,
  input  logic [FRAME_W-1:0]    in_frame_number,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_granted,
  output logic [OUT_CELL_W-1:0] out_cell_index,
  output logic                  out_already_held,
  output logic                  out_evicted_valid,
  output logic [ID_W-1:0]       out_evicted_record
);

  localparam int CI_W = $clog2(MAX_CELLS);
  localparam int RA_W = $clog2(MAX_RECORDS);
  localparam int BW   = $clog2(MAX_CELLS + 1);

  // configuration
  logic [CIU_W-1:0]     ciu_r;
  logic [HOLD_W-1:0]    hold_r;
  logic [BW-1:0]        budget;
  logic                 budget_change;

  // occupancy
  logic [MAX_CELLS-1:0] cv_r;
  logic [MAX_CELLS-1:0] cv_nxt;

  // request
  req_t                 req_r;
  logic [ID_W-1:0]      rec_r;
  logic [FRAME_W-1:0]   frame_r;

  // scan pipeline
  logic [CI_W-1:0]      scan_idx_r;
  logic                 p1_act_r;
  logic [CI_W-1:0]      p1_idx_r;
  logic                 p2_act_r;
  logic                 p2_occ_r;
  logic [CI_W-1:0]      p2_idx_r;
  logic [ID_W-1:0]      p2_owner_r;
  logic                 p3_act_r;
  logic                 p3_occ_r;
  logic [CI_W-1:0]      p3_idx_r;
  logic [ID_W-1:0]      p3_owner_r;
  logic [FRAME_W-1:0]   p3_age_r;
  logic                 occ1;
  logic                 older;

  // scan results
  logic                 hit_r;
  logic [CI_W-1:0]      hit_idx_r;
  logic                 emp_r;
  logic [CI_W-1:0]      emp_idx_r;
  logic                 best_r;
  logic [CI_W-1:0]      best_idx_r;
  logic [ID_W-1:0]      best_owner_r;
  logic [FRAME_W-1:0]   best_age_r;

  // memories
  logic [ID_W-1:0]      owner_rd;
  logic [FRAME_W-1:0]   lw_rd;
  logic                 lw_we;
  logic [RA_W-1:0]      lw_waddr;
  logic [FRAME_W-1:0]   lw_wdata;
  logic [RA_W-1:0]      clr_cnt_r;

  // commit decision
  logic                 rec_ok;
  logic                 c_granted;
  logic [CI_W-1:0]      c_cell;
  logic                 c_held;
  logic                 c_evv;
  logic [ID_W-1:0]      c_evr;
  logic                 place_wr;
  logic [CI_W-1:0]      place_idx;
  logic                 touch_wr;
  logic                 free_wr;

  // result register
  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [OUT_CELL_W-1:0] out_cell_r;
  logic                  out_held_r;
  logic                  out_evv_r;
  logic [ID_W-1:0]       out_evr_r;

  assign budget        = BW'(eff_budget(ciu_r, MAX_CELLS));
  assign budget_change = cfg_we && (cfg_index == REG_CELLS_IN_USE) &&
                         (eff_budget(cfg_wdata[CIU_W-1:0], MAX_CELLS) !=
                          eff_budget(ciu_r, MAX_CELLS));

  assign st.clear_done = (clr_cnt_r == RA_W'(MAX_RECORDS - 1));
  assign st.scan_last  = (scan_idx_r == CI_W'(budget - BW'(1)));
  assign st.pipe_empty = !p1_act_r && !p2_act_r && !p3_act_r;
  assign st.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ciu_r  <= CIU_RESET;
      hold_r <= HOLD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_CELLS_IN_USE) ciu_r <= cfg_wdata[CIU_W-1:0];
      if (cfg_index == REG_HOLD_FRAMES) hold_r <= cfg_wdata[HOLD_W-1:0];
    end
  end

  cah_ram #(.W(ID_W), .D(MAX_CELLS)) u_owner_ram (
    .clk   (clk),
    .we    (cmd.commit && place_wr),
    .waddr (place_idx),
    .wdata (rec_r),
    .raddr (scan_idx_r),
    .rdata (owner_rd)
  );

  assign lw_we    = cmd.clear_step || (cmd.commit && touch_wr);
  assign lw_waddr = cmd.clear_step ? clr_cnt_r : RA_W'(rec_r);
  assign lw_wdata = cmd.clear_step ? '0 : frame_r;

  cah_ram #(.W(FRAME_W), .D(MAX_RECORDS)) u_wanted_ram (
    .clk   (clk),
    .we    (lw_we),
    .waddr (lw_waddr),
    .wdata (lw_wdata),
    .raddr (RA_W'(owner_rd)),
    .rdata (lw_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step && !st.clear_done) begin
      clr_cnt_r <= clr_cnt_r + RA_W'(1);
    end
  end

  assign occ1  = cv_r[p1_idx_r];
  assign older = p3_occ_r && (p3_age_r != '0) &&
                 (p3_age_r > FRAME_W'(hold_r)) && (p3_age_r > best_age_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_act_r <= 1'b0;
      p2_act_r <= 1'b0;
      p3_act_r <= 1'b0;
    end else begin
      p1_act_r <= cmd.scan_step;
      p2_act_r <= p1_act_r;
      p3_act_r <= p2_act_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r   <= scan_idx_r;
    p2_occ_r   <= occ1;
    p2_idx_r   <= p1_idx_r;
    p2_owner_r <= owner_rd;
    p3_occ_r   <= p2_occ_r;
    p3_idx_r   <= p2_idx_r;
    p3_owner_r <= p2_owner_r;
    p3_age_r   <= frame_r - lw_rd;
    if (cmd.accept) begin
      req_r      <= req_t'(in_req_type);
      rec_r      <= in_record_id;
      frame_r    <= in_frame_number;
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
      emp_r      <= 1'b0;
      best_r     <= 1'b0;
      best_age_r <= '0;
    end else begin
      if (cmd.scan_step) scan_idx_r <= scan_idx_r + CI_W'(1);
      if (p1_act_r) begin
        if (occ1 && (owner_rd == rec_r)) begin
          hit_r     <= 1'b1;
          hit_idx_r <= p1_idx_r;
        end
        if (!occ1 && !emp_r) begin
          emp_r     <= 1'b1;
          emp_idx_r <= p1_idx_r;
        end
      end
      if (p3_act_r && older) begin
        best_r       <= 1'b1;
        best_idx_r   <= p3_idx_r;
        best_owner_r <= p3_owner_r;
        best_age_r   <= p3_age_r;
      end
    end
  end

  always_comb begin
    rec_ok    = (32'(rec_r) < 32'(MAX_RECORDS));
    c_granted = 1'b0;
    c_cell    = '0;
    c_held    = 1'b0;
    c_evv     = 1'b0;
    c_evr     = '0;
    place_wr  = 1'b0;
    place_idx = emp_idx_r;
    touch_wr  = 1'b0;
    free_wr   = 1'b0;
    if (rec_ok) begin
      case (req_r)
        REQ_TOUCH: begin
          touch_wr = 1'b1;
          if (hit_r) begin
            c_granted = 1'b1;
            c_cell    = hit_idx_r;
          end
        end
        REQ_PLACE: begin
          if (hit_r) begin
            c_held    = 1'b1;
            c_granted = 1'b1;
            c_cell    = hit_idx_r;
          end else if (emp_r) begin
            place_wr  = 1'b1;
            place_idx = emp_idx_r;
            c_granted = 1'b1;
            c_cell    = emp_idx_r;
          end else if (best_r) begin
            place_wr  = 1'b1;
            place_idx = best_idx_r;
            c_granted = 1'b1;
            c_cell    = best_idx_r;
            c_evv     = 1'b1;
            c_evr     = best_owner_r;
          end
        end
        REQ_FREE: begin
          free_wr = hit_r;
        end
        default: begin
          if (hit_r) begin
            c_granted = 1'b1;
            c_cell    = hit_idx_r;
          end
        end
      endcase
    end
  end

  always_comb begin
    cv_nxt = cv_r;
    if (cmd.commit) begin
      if (place_wr) cv_nxt[place_idx] = 1'b1;
      if (free_wr) cv_nxt[hit_idx_r] = 1'b0;
    end
    if (budget_change) cv_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
    end else begin
      cv_r <= cv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_granted_r <= c_granted;
      out_cell_r    <= OUT_CELL_W'(c_cell);
      out_held_r    <= c_held;
      out_evv_r     <= c_evv;
      out_evr_r     <= c_evr;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_cell_index     = out_cell_r;
  assign out_already_held   = out_held_r;
  assign out_evicted_valid  = out_evv_r;
  assign out_evicted_record = out_evr_r;

endmodule

/* hdl/cell_allocator_with_hold_time.sv */
`timescale 1ns / 1ps

// Cell allocator with least-recently-wanted replacement and a hold time. Each request
// (touch, place, free, or probe) is handled one at a time: the cells 0 .. budget-1 are
// scanned one per cycle from the cell owner RAM, each owner's last-wanted frame is looked
// up in the record RAM, and the result is registered. The next request is taken as soon as
// the result sits in the output register, even if that result has not yet been transferred.
// After reset a clearing pass zeroes the last-wanted frames of all MAX_RECORDS records,
// during which no request is taken; configuration writes are accepted throughout. A write
// to cells_in_use that changes the effective budget empties every cell.
module cell_allocator_with_hold_time import cah_pkg::*; #(
  parameter int MAX_CELLS   = DEF_MAX_CELLS,
  parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [ID_W-1:0]       in_record_id,
  input  logic [FRAME_W-1:0]    in_frame_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_granted,
  output logic [OUT_CELL_W-1:0] out_cell_index,
  output logic                  out_already_held,
  output logic                  out_evicted_valid,
  output logic [ID_W-1:0]       out_evicted_record,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  cmd_t    cmd;
  status_t st;

  cah_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  cah_dp #(
    .MAX_CELLS   (MAX_CELLS),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_req_type        (in_req_type),
    .in_record_id       (in_record_id),
    .in_frame_number    (in_frame_number),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_granted        (out_granted),
    .out_cell_index     (out_cell_index),
    .out_already_held   (out_already_held),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_record (out_evicted_record)
  );

endmodule

/* hdl/cah_chk.sv */
`timescale 1ns / 1ps
`include "cell_allocator_with_hold_time_defines.svh"

module cah_chk import cah_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_granted,
  input logic [OUT_CELL_W-1:0] out_cell_index,
  input logic                  out_already_held,
  input logic                  out_evicted_valid,
  input logic [ID_W-1:0]       out_evicted_record
);

  logic [OUT_CELL_W+ID_W+2:0] res;

  assign res = {out_granted, out_cell_index, out_already_held, out_evicted_valid,
                out_evicted_record};

  `CAH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res), "result moved while stalled")
  `CAH_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `CAH_ASSERT_SAME(a_evict_grant, out_valid && out_evicted_valid, out_granted && !out_already_held, "bad eviction")
  `CAH_ASSERT_SAME(a_no_grant, out_valid && !out_granted, out_cell_index == '0 && !out_evicted_valid, "stray fields")

endmodule

bind cell_allocator_with_hold_time cah_chk u_cah_chk (.*);

/* dv/cah_grant_checker.sv */
`timescale 1ns / 1ps

module cah_grant_checker import cah_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [ID_W-1:0]       in_record_id,
  input  logic [FRAME_W-1:0]    in_frame_number,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_granted,
  input  logic [OUT_CELL_W-1:0] out_cell_index,
  input  logic                  out_already_held,
  input  logic                  out_evicted_valid,
  input  logic [ID_W-1:0]       out_evicted_record,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    n_waiting,
  output int                    n_errors
);

  localparam int NCELLS = DEF_MAX_CELLS;
  localparam int NRECS  = DEF_MAX_RECORDS;

  typedef struct packed {
    logic                  granted;
    logic [OUT_CELL_W-1:0] cell_idx;
    logic                  held;
    logic                  ev_valid;
    logic [ID_W-1:0]       ev_rec;
  } grant_t;

  logic                  owner_live [NCELLS];
  logic [ID_W-1:0]       owner_of   [NCELLS];
  logic                  rec_live   [NRECS];
  logic [OUT_CELL_W-1:0] cell_of    [NRECS];
  logic [FRAME_W-1:0]    wanted_at  [NRECS];
  logic [CIU_W-1:0]      budget_reg;
  logic [HOLD_W-1:0]     hold_reg;

  grant_t pending_grants [$];
  int     errs = 0;

  initial begin
    n_waiting = 0;
    n_errors  = 0;
  end

  function automatic int budget_of(input logic [CIU_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    return (int'(v) > NCELLS) ? NCELLS : int'(v);
  endfunction

  function automatic void empty_cells();
    for (int c = 0; c < NCELLS; c++) begin
      owner_live[c] = 1'b0;
      owner_of[c]   = '0;
    end
    for (int r = 0; r < NRECS; r++) begin
      rec_live[r] = 1'b0;
      cell_of[r]  = '0;
    end
  endfunction

  function automatic grant_t serve_request(input req_t req, input logic [ID_W-1:0] rec,
                                           input logic [FRAME_W-1:0] frame);
    grant_t             g;
    int                 n;
    int                 best;
    logic               found;
    logic               took_empty;
    logic [FRAME_W-1:0] age;
    logic [FRAME_W-1:0] best_age;
    logic [ID_W-1:0]    victim;
    g          = '0;
    best       = 0;
    found      = 1'b0;
    took_empty = 1'b0;
    best_age   = '0;
    case (req)
      REQ_TOUCH: begin
        wanted_at[rec] = frame;
      end
      REQ_PLACE: begin
        if (rec_live[rec]) begin
          g.held = 1'b1;
        end else begin
          n = budget_of(budget_reg);
          for (int c = 0; c < n; c++) begin
            if (!took_empty) begin
              if (!owner_live[c]) begin
                best       = c;
                found      = 1'b1;
                took_empty = 1'b1;
              end else begin
                age = frame - wanted_at[owner_of[c]];
                if (age != '0 && age > FRAME_W'(hold_reg) && (!found || age > best_age)) begin
                  best_age = age;
                  best     = c;
                  found    = 1'b1;
                end
              end
            end
          end
          if (found) begin
            if (owner_live[best]) begin
              victim           = owner_of[best];
              rec_live[victim] = 1'b0;
              cell_of[victim]  = '0;
              g.ev_valid       = 1'b1;
              g.ev_rec         = victim;
            end
            owner_live[best] = 1'b1;
            owner_of[best]   = rec;
            rec_live[rec]    = 1'b1;
            cell_of[rec]     = OUT_CELL_W'(best);
          end
        end
      end
      REQ_FREE: begin
        if (rec_live[rec]) begin
          owner_live[cell_of[rec]] = 1'b0;
          owner_of[cell_of[rec]]   = '0;
          rec_live[rec]            = 1'b0;
          cell_of[rec]             = '0;
        end
      end
      default: begin
      end
    endcase
    if (rec_live[rec]) begin
      g.granted  = 1'b1;
      g.cell_idx = cell_of[rec];
    end
    return g;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    grant_t           want;
    grant_t           next_grant;
    logic [CIU_W-1:0] nv;
    if (!rst_n) begin
      budget_reg = CIU_RESET;
      hold_reg   = HOLD_RESET;
      empty_cells();
      for (int r = 0; r < NRECS; r++) begin
        wanted_at[r] = '0;
      end
      pending_grants.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_grants.size() == 0) begin
          $error("result transfer with no request outstanding");
          errs++;
        end else begin
          want = pending_grants.pop_front();
          check_field("granted", 32'(want.granted), 32'(out_granted));
          check_field("cell_index", 32'(want.cell_idx), 32'(out_cell_index));
          check_field("already_held", 32'(want.held), 32'(out_already_held));
          check_field("evicted_valid", 32'(want.ev_valid), 32'(out_evicted_valid));
          check_field("evicted_record", 32'(want.ev_rec), 32'(out_evicted_record));
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_CELLS_IN_USE: begin
            nv = cfg_wdata[CIU_W-1:0];
            if (budget_of(nv) != budget_of(budget_reg)) begin
              empty_cells();
            end
            budget_reg = nv;
          end
          default: begin
            hold_reg = cfg_wdata[HOLD_W-1:0];
          end
        endcase
      end
      if (in_valid && in_ready) begin
        next_grant     = serve_request(req_t'(in_req_type), in_record_id, in_frame_number);
        pending_grants = {pending_grants, next_grant};
      end
    end
    n_waiting <= pending_grants.size();
    n_errors  <= errs;
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import cah_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [REQ_W-1:0]      in_req_type = '0;
  logic [ID_W-1:0]       in_record_id = '0;
  logic [FRAME_W-1:0]    in_frame_number = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_granted;
  logic [OUT_CELL_W-1:0] out_cell_index;
  logic                  out_already_held;
  logic                  out_evicted_valid;
  logic [ID_W-1:0]       out_evicted_record;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  int                    grants_waiting;
  int                    grant_errors;
  int                    burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cell_allocator_with_hold_time dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_record_id       (in_record_id),
    .in_frame_number    (in_frame_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_granted        (out_granted),
    .out_cell_index     (out_cell_index),
    .out_already_held   (out_already_held),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_record (out_evicted_record),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  cah_grant_checker u_grant_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_record_id       (in_record_id),
    .in_frame_number    (in_frame_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_granted        (out_granted),
    .out_cell_index     (out_cell_index),
    .out_already_held   (out_already_held),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_record (out_evicted_record),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .n_waiting          (grants_waiting),
    .n_errors           (grant_errors)
  );

  task automatic offer(input req_t req, input logic [ID_W-1:0] rec,
                       input logic [FRAME_W-1:0] frame);
    int gap;
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_record_id    <= rec;
    in_frame_number <= frame;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grants_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] budget, input logic [CFG_W-1:0] hold);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CELLS_IN_USE;
    cfg_wdata <= budget;
    @(posedge clk);
    cfg_index <= REG_HOLD_FRAMES;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: stall patterns plus one long hold-off
  initial begin : result_sink
    int seg_left;
    int mode;
    int taken;
    bit long_done;
    seg_left  = 0;
    mode      = 0;
    taken     = 0;
    long_done = 1'b0;
    @(posedge clk);
    forever begin
      if (out_valid && out_ready) taken++;
      if (!long_done && taken >= 300) begin
        long_done = 1'b1;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 40);
          mode     = $urandom_range(0, 3);
        end
        seg_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0]    pool [96];
    logic [CFG_W-1:0]   budget_w;
    logic [CFG_W-1:0]   hold_w;
    logic [FRAME_W-1:0] now_frame;
    int                 eff;
    int                 pool_n;
    int                 step_max;
    int                 pick;
    logic [ID_W-1:0]    rec;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: budget 16, hold 120
    offer(REQ_TOUCH, 10'd0, 32'd0);
    offer(REQ_TOUCH, 10'd1023, 32'hFFFF_FFFF);
    offer(REQ_PROBE, 10'd5, 32'd0);
    offer(REQ_FREE, 10'd7, 32'd0);
    offer(REQ_PLACE, 10'd0, 32'd0);
    offer(REQ_PLACE, 10'd0, 32'd0);
    offer(REQ_PROBE, 10'd0, 32'd0);
    offer(REQ_PLACE, 10'd1023, 32'd0);
    for (int i = 0; i < 14; i++) begin
      offer(REQ_PLACE, 10'(100 + i), 32'd1);
    end
    // all cells held, no owner past its hold time
    offer(REQ_PLACE, 10'd200, 32'd10);
    // stalest owner wins across the frame wrap
    offer(REQ_PLACE, 10'd200, 32'd500);
    offer(REQ_FREE, 10'd200, 32'd500);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin budget_w = 16'd0;     hold_w = 16'd5;     end
        1: begin budget_w = 16'd1;     hold_w = 16'd0;     end
        2: begin budget_w = 16'd4;     hold_w = 16'd30;    end
        3: begin budget_w = 16'd16;    hold_w = 16'd120;   end
        4: begin budget_w = 16'd64;    hold_w = 16'hFFFF;  end
        5: begin budget_w = 16'd100;   hold_w = 16'd1000;  end
        6: begin budget_w = 16'd127;   hold_w = 16'd0;     end
        default: begin budget_w = 16'hFF88; hold_w = 16'd300; end
      endcase
      drain();
      write_regs(budget_w, hold_w);
      eff = (budget_w[CIU_W-1:0] == '0) ? 1 :
            (int'(budget_w[CIU_W-1:0]) > 64 ? 64 : int'(budget_w[CIU_W-1:0]));
      pool_n = eff + $urandom_range(2, eff + 4);
      if (pool_n > 96) pool_n = 96;
      for (int k = 0; k < pool_n; k++) begin
        pool[k] = ID_W'($urandom_range(0, 1023));
      end
      step_max  = int'(hold_w) / 8 + 2;
      now_frame = (ph == 2) ? 32'hFFFF_FF00 : $urandom();
      for (int k = 0; k < 196; k++) begin
        now_frame += $urandom_range(0, step_max);
        pick = $urandom_range(0, 99);
        rec  = pool[$urandom_range(0, pool_n - 1)];
        if (pick < 35) begin
          offer(REQ_TOUCH, rec, now_frame);
        end else if (pick < 80) begin
          offer(REQ_PLACE, rec, now_frame);
        end else if (pick < 90) begin
          offer(REQ_FREE, rec, now_frame);
        end else if (pick < 95) begin
          offer(REQ_PROBE, rec, now_frame);
        end else begin
          offer(req_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 1023)), $urandom());
        end
      end
    end

    drain();
    repeat (80) @(posedge clk);
    if (grant_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
